// ----- hdl/wfft_pkg.sv -----
// Package for the windowed radix-2 FFT unit: shared types, fixed widths and
// the elaboration-time functions that build the cosine and window tables.
// Depends on nothing; every other file in hdl imports it.
package wfft_pkg;

    localparam int WORD_W  = 26;
    localparam int SPEC_W  = 24;
    localparam int COEF_W  = 16;
    localparam int SMP_W   = 16;
    localparam int BIN_W   = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int PROD_W  = 42;
    localparam int SUM_W   = 28;
    localparam int WPROD_W = 17;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_RD_WAIT,
        ST_RV_RD,
        ST_RV_WA,
        ST_RV_WB,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WT,
        ST_BF_WB,
        ST_CP_RD,
        ST_CP_WR
    } state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] re;
        logic signed [WORD_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } bf_ctrl_t;

    // One Taylor term divided by the constant denominator of step n.
    function automatic logic [63:0] div_term(input logic [63:0] x, input logic odd,
                                             input logic [3:0] n);
        logic [63:0] q;
        case ({odd, n})
            {1'b0, 4'd1}:  q = x / 64'd2;
            {1'b0, 4'd2}:  q = x / 64'd12;
            {1'b0, 4'd3}:  q = x / 64'd30;
            {1'b0, 4'd4}:  q = x / 64'd56;
            {1'b0, 4'd5}:  q = x / 64'd90;
            {1'b0, 4'd6}:  q = x / 64'd132;
            {1'b0, 4'd7}:  q = x / 64'd182;
            {1'b0, 4'd8}:  q = x / 64'd240;
            {1'b0, 4'd9}:  q = x / 64'd306;
            {1'b0, 4'd10}: q = x / 64'd380;
            {1'b0, 4'd11}: q = x / 64'd462;
            {1'b0, 4'd12}: q = x / 64'd552;
            {1'b1, 4'd1}:  q = x / 64'd6;
            {1'b1, 4'd2}:  q = x / 64'd20;
            {1'b1, 4'd3}:  q = x / 64'd42;
            {1'b1, 4'd4}:  q = x / 64'd72;
            {1'b1, 4'd5}:  q = x / 64'd110;
            {1'b1, 4'd6}:  q = x / 64'd156;
            {1'b1, 4'd7}:  q = x / 64'd210;
            {1'b1, 4'd8}:  q = x / 64'd272;
            {1'b1, 4'd9}:  q = x / 64'd342;
            {1'b1, 4'd10}: q = x / 64'd420;
            {1'b1, 4'd11}: q = x / 64'd506;
            {1'b1, 4'd12}: q = x / 64'd600;
            default:       q = x;
        endcase
        return q;
    endfunction

    // Cosine (odd = 0) or sine (odd = 1) of a first-quadrant angle in Q30.
    function automatic logic signed [63:0] series(input logic [63:0] t, input logic odd);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        t2   = (t * t) >> 30;
        term = odd ? t : ONE_Q30;
        sum  = signed'(term);
        for (int n = 1; n <= 12; n++) begin
            term = div_term((term * t2) >> 30, odd, 4'(n));
            if ((n & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] round15(input logic signed [63:0] v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [COEF_W-1:0] clamp16(input logic signed [63:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > 64'sd32767) begin
            r = 16'sd32767;
        end else if (v < -64'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = COEF_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] cos_q15(input logic [63:0] th,
                                                         input logic [1:0] quad);
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic signed [63:0] v;
        c = series(th, 1'b0);
        s = series(th, 1'b1);
        case (quad)
            2'd0:    v = c;
            2'd1:    v = -s;
            2'd2:    v = -c;
            default: v = s;
        endcase
        return clamp16(round15(v));
    endfunction

    function automatic logic signed [COEF_W-1:0] win_q15(input logic signed [COEF_W-1:0] c1,
                                                         input logic signed [COEF_W-1:0] c2,
                                                         input logic signed [COEF_W-1:0] c3);
        logic signed [63:0] e1;
        logic signed [63:0] e2;
        logic signed [63:0] e3;
        logic signed [63:0] acc;
        e1  = c1;
        e2  = c2;
        e3  = c3;
        acc = 64'sd11658 * 64'sd32768 - 64'sd15971 * e1 + 64'sd4726 * e2 - 64'sd413 * e3;
        return clamp16(round15(acc));
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > (SUM_W+1)'(33554431)) begin
            r = 26'sd33554431;
        end else if (v < -(SUM_W+1)'(33554432)) begin
            r = -26'sd33554432;
        end else begin
            r = WORD_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [SPEC_W-1:0] sat_spec(input logic signed [WORD_W-1:0] v);
        logic signed [SPEC_W-1:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -26'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = SPEC_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hdl/wfft_rom.sv -----
// Twiddle and window coefficient tables, built at elaboration, with
// registered reads. Depends on wfft_pkg.
module wfft_rom #(
    parameter int POINTS = 256
) (
    input  logic                                aclk,
    input  logic [$clog2(POINTS)-1:0]           tw_addr_a,
    input  logic [$clog2(POINTS)-1:0]           tw_addr_b,
    input  logic [$clog2(POINTS)-1:0]           win_addr,
    output logic signed [wfft_pkg::COEF_W-1:0]  cr,
    output logic signed [wfft_pkg::COEF_W-1:0]  ci,
    output logic signed [wfft_pkg::COEF_W-1:0]  win
);
    import wfft_pkg::*;

    localparam int Q = POINTS / 4;

    logic signed [COEF_W-1:0] cos_tab [POINTS];
    logic signed [COEF_W-1:0] win_tab [POINTS];

    for (genvar a = 0; a < POINTS; a++) begin : g_rom
        localparam int I2 = (2 * a) % POINTS;
        localparam int I3 = (3 * a) % POINTS;
        localparam logic [63:0] TH1 = (HALF_PI_Q30 * 64'(a % Q)) / 64'(Q);
        localparam logic [63:0] TH2 = (HALF_PI_Q30 * 64'(I2 % Q)) / 64'(Q);
        localparam logic [63:0] TH3 = (HALF_PI_Q30 * 64'(I3 % Q)) / 64'(Q);
        localparam logic signed [COEF_W-1:0] C1 = cos_q15(TH1, 2'(a / Q));
        localparam logic signed [COEF_W-1:0] C2 = cos_q15(TH2, 2'(I2 / Q));
        localparam logic signed [COEF_W-1:0] C3 = cos_q15(TH3, 2'(I3 / Q));
        localparam logic signed [COEF_W-1:0] W  = win_q15(C1, C2, C3);
        assign cos_tab[a] = C1;
        assign win_tab[a] = W;
    end

    always_ff @(posedge aclk) begin
        cr  <= cos_tab[tw_addr_a];
        ci  <= cos_tab[tw_addr_b];
        win <= win_tab[win_addr];
    end

endmodule

// ----- hdl/wfft_ram.sv -----
// Complex working store: one write port and two registered read ports.
// Depends on wfft_pkg for the complex word type.
module wfft_ram #(
    parameter int DEPTH = 256
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr_b,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wfft_pkg::cplx_t             wr_data,
    output wfft_pkg::cplx_t             rd_q_a,
    output wfft_pkg::cplx_t             rd_q_b
);
    import wfft_pkg::*;

    cplx_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_a <= mem[rd_addr_a];
            rd_q_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- hdl/wfft_bfly.sv -----
// Radix-2 butterfly datapath: registered products, registered rounded sums,
// then saturating add and subtract. Depends on wfft_pkg.
module wfft_bfly (
    input  logic                               aclk,
    input  wfft_pkg::bf_ctrl_t                 ctrl,
    input  wfft_pkg::cplx_t                    a,
    input  wfft_pkg::cplx_t                    b,
    input  logic signed [wfft_pkg::COEF_W-1:0] cr,
    input  logic signed [wfft_pkg::COEF_W-1:0] ci,
    output wfft_pkg::cplx_t                    top,
    output wfft_pkg::cplx_t                    bot
);
    import wfft_pkg::*;

    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0] p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic signed [PROD_W:0]   t1, t2;
    logic signed [SUM_W-1:0]  s1_reg, s2_reg, s1_next, s2_next;

    always_comb begin
        p_rr_next = b.re * cr;
        p_ii_next = b.im * ci;
        p_ri_next = b.re * ci;
        p_ir_next = b.im * cr;
        t1 = (PROD_W+1)'(p_rr_reg) - (PROD_W+1)'(p_ii_reg);
        t2 = (PROD_W+1)'(p_ri_reg) + (PROD_W+1)'(p_ir_reg);
        s1_next = SUM_W'((t1 + (PROD_W+1)'(16384)) >>> 15);
        s2_next = SUM_W'((t2 + (PROD_W+1)'(16384)) >>> 15);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p_rr_reg <= p_rr_next;
            p_ii_reg <= p_ii_next;
            p_ri_reg <= p_ri_next;
            p_ir_reg <= p_ir_next;
        end
        if (ctrl.sum_en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    always_comb begin
        top.re = sat_word((SUM_W+1)'(a.re) + (SUM_W+1)'(s1_reg));
        top.im = sat_word((SUM_W+1)'(a.im) + (SUM_W+1)'(s2_reg));
        bot.re = sat_word((SUM_W+1)'(a.re) - (SUM_W+1)'(s1_reg));
        bot.im = sat_word((SUM_W+1)'(a.im) - (SUM_W+1)'(s2_reg));
    end

endmodule

// ----- hdl/windowed_radix2_fft_real_out_unit.sv -----
// Windowed radix-2 FFT unit, real part out. Uses wfft_pkg, wfft_rom, wfft_ram, wfft_bfly.
// A sample load passes through ST_LD_MUL and ST_LD_WR; a bin read raises m_tvalid from
// ST_RD_WAIT; the unit is then ready again (later if an earlier result is still held).
// The last sample of a frame then runs the reorder, butterfly and copy passes, paced
// by the single butterfly and the one write port of the working store.
// Reset (aresetn low, synchronous) clears control; the spectrum reads as zero until
// the first frame has been transformed.
module windowed_radix2_fft_real_out_unit #(
    parameter int POINTS = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wfft_pkg::S_DATA_W-1:0] s_tdata,   // sample [15:0], bin_index [23:16]
    input  logic                          s_tuser,   // mode: 0 load sample, 1 read bin
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wfft_pkg::M_DATA_W-1:0] m_tdata    // bin_real [23:0], bin_number [31:24]
);
    import wfft_pkg::*;

    localparam int AW = $clog2(POINTS);
    localparam int SW = $clog2(AW);

    // Control state.
    state_t            state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [AW:0]       k_reg, k_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [SW-1:0]     stg_reg, stg_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              spec_valid_reg, spec_valid_next;

    // Payload registers.
    logic signed [SMP_W-1:0]   smp_reg;
    logic signed [WPROD_W-1:0] wprod_reg, wprod_next;
    logic [SPEC_W-1:0]         spec_q_reg;
    logic [BIN_W-1:0]          bin_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // Spectrum store, written once per frame by the copy pass.
    logic [SPEC_W-1:0] spec_mem [POINTS];

    logic              in_xfer;
    logic              out_load;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     rev;
    logic [AW-1:0]     h;
    logic [AW:0]       m;
    logic [AW:0]       k_sum;
    logic [AW-1:0]     kp;
    logic              rv_swap, idx_last, j_last, stg_last;
    logic signed [31:0] wp;

    // Memory, table and butterfly hook-up.
    logic              ram_rd_en, ram_we;
    logic [AW-1:0]     ram_rd_a, ram_rd_b, ram_wr_addr;
    cplx_t             ram_wr_data, ram_q_a, ram_q_b;
    logic [AW-1:0]     tw_a, tw_b;
    logic signed [COEF_W-1:0] cr, ci, win;
    bf_ctrl_t          bf_ctrl;
    cplx_t             bf_top, bf_bot;
    logic              spec_we;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The read port of the spectrum follows the index bits that address it; the index
    // wraps modulo the frame length while the echo keeps all eight bits.
    logic [AW-1:0] bin_addr;
    assign bin_addr = AW'(s_tdata[SMP_W +: BIN_W]);

    // Index bookkeeping shared by the reorder, butterfly and copy passes.
    always_comb begin
        idx = k_reg[AW-1:0];
        for (int b = 0; b < AW; b++) begin
            rev[b] = idx[AW-1-b];
        end
        h        = AW'(1) << stg_reg;
        m        = {h, 1'b0};
        k_sum    = k_reg + m;
        kp       = idx + h;
        rv_swap  = idx < rev;
        idx_last = idx == AW'(POINTS - 1);
        j_last   = j_reg == (h - AW'(1));
        stg_last = stg_reg == SW'(AW - 1);
        tw_a     = j_reg << (SW'(AW - 1) - stg_reg);
        tw_b     = tw_a + AW'(POINTS / 4);
        wp       = smp_reg * win;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = s_tuser ? ST_RD_WAIT : ST_LD_MUL;
                end
            end
            ST_LD_MUL:  state_next = ST_LD_WR;
            ST_LD_WR:   state_next = (cnt_reg == AW'(POINTS - 1)) ? ST_RV_RD : ST_IDLE;
            ST_RD_WAIT: state_next = (!m_tvalid_reg || m_tready) ? ST_IDLE : ST_RD_WAIT;
            ST_RV_RD: begin
                if (rv_swap) begin
                    state_next = ST_RV_WA;
                end else if (idx_last) begin
                    state_next = ST_BF_RD;
                end
            end
            ST_RV_WA:   state_next = ST_RV_WB;
            ST_RV_WB:   state_next = idx_last ? ST_BF_RD : ST_RV_RD;
            ST_BF_RD:   state_next = ST_BF_MUL;
            ST_BF_MUL:  state_next = ST_BF_SUM;
            ST_BF_SUM:  state_next = ST_BF_WT;
            ST_BF_WT:   state_next = ST_BF_WB;
            ST_BF_WB: begin
                if (k_sum[AW] && j_last && stg_last) begin
                    state_next = ST_CP_RD;
                end else begin
                    state_next = ST_BF_RD;
                end
            end
            ST_CP_RD:   state_next = ST_CP_WR;
            ST_CP_WR:   state_next = idx_last ? ST_IDLE : ST_CP_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs and counter updates.
    always_comb begin
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        stg_next        = stg_reg;
        spec_valid_next = spec_valid_reg;
        wprod_next      = wprod_reg;
        ram_rd_en       = 1'b0;
        ram_rd_a        = idx;
        ram_rd_b        = rev;
        ram_we          = 1'b0;
        ram_wr_addr     = idx;
        ram_wr_data     = ram_q_b;
        bf_ctrl         = '0;
        spec_we         = 1'b0;
        out_load        = 1'b0;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_LD_MUL: begin
                wprod_next = WPROD_W'((wp + 32'sd16384) >>> 15);
            end
            ST_LD_WR: begin
                ram_we         = 1'b1;
                ram_wr_addr    = cnt_reg;
                ram_wr_data.re = WORD_W'(wprod_reg);
                ram_wr_data.im = '0;
                cnt_next       = cnt_reg + AW'(1);
                k_next         = '0;
            end
            ST_RD_WAIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {bin_reg, spec_valid_reg ? spec_q_reg : SPEC_W'(0)};
                end
            end
            ST_RV_RD: begin
                ram_rd_en = 1'b1;
                if (!rv_swap) begin
                    k_next = idx_last ? '0 : k_reg + (AW+1)'(1);
                    j_next = '0;
                    stg_next = '0;
                end
            end
            ST_RV_WA: begin
                ram_we      = 1'b1;
                ram_wr_data = ram_q_b;
            end
            ST_RV_WB: begin
                ram_we      = 1'b1;
                ram_wr_addr = rev;
                ram_wr_data = ram_q_a;
                k_next      = idx_last ? '0 : k_reg + (AW+1)'(1);
                j_next      = '0;
                stg_next    = '0;
            end
            ST_BF_RD: begin
                ram_rd_en = 1'b1;
                ram_rd_b  = kp;
            end
            ST_BF_MUL: bf_ctrl.mul_en = 1'b1;
            ST_BF_SUM: bf_ctrl.sum_en = 1'b1;
            ST_BF_WT: begin
                ram_we      = 1'b1;
                ram_wr_data = bf_top;
            end
            ST_BF_WB: begin
                ram_we      = 1'b1;
                ram_wr_addr = kp;
                ram_wr_data = bf_bot;
                if (!k_sum[AW]) begin
                    k_next = k_sum;
                end else if (!j_last) begin
                    j_next = j_reg + AW'(1);
                    k_next = (AW+1)'(j_reg) + (AW+1)'(1);
                end else begin
                    j_next   = '0;
                    k_next   = '0;
                    stg_next = stg_last ? stg_reg : stg_reg + SW'(1);
                end
            end
            ST_CP_RD: ram_rd_en = 1'b1;
            ST_CP_WR: begin
                spec_we = 1'b1;
                k_next  = idx_last ? '0 : k_reg + (AW+1)'(1);
                if (idx_last) begin
                    spec_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            k_reg          <= '0;
            j_reg          <= '0;
            stg_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            spec_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            j_reg          <= j_next;
            stg_reg        <= stg_next;
            m_tvalid_reg   <= m_tvalid_next;
            spec_valid_reg <= spec_valid_next;
        end
    end

    // Payload registers and the spectrum store.
    always_ff @(posedge aclk) begin
        wprod_reg <= wprod_next;
        if (in_xfer) begin
            smp_reg <= signed'(s_tdata[SMP_W-1:0]);
            bin_reg <= s_tdata[SMP_W +: BIN_W];
        end
        if (in_xfer && s_tuser) begin
            spec_q_reg <= spec_mem[bin_addr];
        end
        if (spec_we) begin
            spec_mem[idx] <= sat_spec(ram_q_a.re);
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    wfft_rom #(.POINTS(POINTS)) u_rom (
        .aclk      (aclk),
        .tw_addr_a (tw_a),
        .tw_addr_b (tw_b),
        .win_addr  (cnt_reg),
        .cr        (cr),
        .ci        (ci),
        .win       (win)
    );

    wfft_ram #(.DEPTH(POINTS)) u_ram (
        .aclk      (aclk),
        .rd_en     (ram_rd_en),
        .rd_addr_a (ram_rd_a),
        .rd_addr_b (ram_rd_b),
        .we        (ram_we),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_q_a    (ram_q_a),
        .rd_q_b    (ram_q_b)
    );

    wfft_bfly u_bfly (
        .aclk (aclk),
        .ctrl (bf_ctrl),
        .a    (ram_q_a),
        .b    (ram_q_b),
        .cr   (cr),
        .ci   (ci),
        .top  (bf_top),
        .bot  (bf_bot)
    );

endmodule

// ----- hdl/wfft_chk.sv -----
// Port-level checker for the windowed FFT unit, bound to the top level.
// Depends on wfft_pkg for the stream widths.
module wfft_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [wfft_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wfft_pkg::M_DATA_W-1:0] m_tdata
);
    import wfft_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_read_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> ##1
            (m_tvalid && m_tdata[31:24] == $past(s_tdata[23:16], 2)))
        else $error("bin read result missing or wrong echo");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind windowed_radix2_fft_real_out_unit wfft_chk u_wfft_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
